[rtl/core/lac_pkg.sv]
// ----------------------------------------------------------------------------
// lac_pkg
// Shared widths, codes, the step table of the sequencer and saturation
// helpers for the lever-arm acceleration compensation block.
// ----------------------------------------------------------------------------
package lac_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int RATE_W     = 23;
  localparam int ACCEL_W    = 25;
  localparam int STEP_W     = 14;
  localparam int LEVER_W    = 20;
  localparam int THR_W      = 22;
  localparam int TAU_W      = 20;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;

  localparam int OPD_W  = 33;   // signed operand of the shared multiplier
  localparam int MAG_W  = 32;   // operand magnitude
  localparam int PROD_W = 2 * MAG_W;
  localparam int ACC_W  = 56;   // signed accumulator
  localparam int NUM_W  = 48;   // dividend magnitude
  localparam int DEN_W  = 21;   // tau + step
  localparam int T_W    = 28;   // w x r after rounding
  localparam int CE_W   = 38;   // centripetal and euler terms
  localparam int NORM_W = 47;
  localparam int SIDX_W = 5;

  localparam logic [SIDX_W-1:0] LAST_STEP = SIDX_W'(27);
  localparam int US_PER_S = 1000000;

  localparam logic [CFG_IDX_W-1:0] REG_LEVER_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LEVER_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LEVER_Z = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_THR     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_TAU     = CFG_IDX_W'(4);

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1 << (FRAC_BITS - 1));
  localparam logic [TAU_W-1:0] TAU_RESET = TAU_W'(20000);

  typedef enum logic [2:0] {
    SRC_DW, SRC_MEGA, SRC_DT, SRC_W, SRC_R, SRC_T, SRC_S, SRC_THR
  } src_t;

  typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB} acc_mode_t;

  typedef enum logic [2:0] {
    WB_NONE, WB_DIV, WB_T, WB_C, WB_E, WB_NORM, WB_APPLY
  } wb_t;

  typedef struct packed {
    src_t      a_src;
    logic [1:0] a_idx;
    src_t      b_src;
    logic [1:0] b_idx;
    acc_mode_t mode;
    wb_t       wb;
    logic [1:0] ix;
  } step_t;

  function automatic logic [1:0] next3(input logic [1:0] k);
    return (k == 2'd2) ? 2'd0 : k + 2'd1;
  endfunction

  // one product per step; cross products take two steps per component
  function automatic step_t step_entry(input logic [SIDX_W-1:0] idx);
    step_t e;
    logic [SIDX_W-1:0] j;
    logic [2:0] rem;
    logic [1:0] k;
    logic [1:0] grp;
    e = '{SRC_W, 2'd0, SRC_W, 2'd0, ACC_LOAD, WB_NONE, 2'd0};
    j = idx - SIDX_W'(6);
    grp = 2'd0;
    rem = 3'd0;
    if (idx < SIDX_W'(6)) begin
      k = idx[2:1];
      e.ix = k;
      if (!idx[0]) begin
        e.a_src = SRC_DW;
        e.a_idx = k;
        e.b_src = SRC_MEGA;
      end else begin
        e.a_src = SRC_DT;
        e.b_src = SRC_S;
        e.b_idx = k;
        e.mode  = ACC_SUB;
        e.wb    = WB_DIV;
      end
    end else if (idx < SIDX_W'(24)) begin
      if (j < SIDX_W'(6)) begin
        grp = 2'd0;
        rem = j[2:0];
      end else if (j < SIDX_W'(12)) begin
        grp = 2'd1;
        rem = 3'(j - SIDX_W'(6));
      end else begin
        grp = 2'd2;
        rem = 3'(j - SIDX_W'(12));
      end
      k = rem[2:1];
      e.ix    = k;
      e.a_src = (grp == 2'd2) ? SRC_S : SRC_W;
      e.b_src = (grp == 2'd1) ? SRC_T : SRC_R;
      if (!rem[0]) begin
        e.a_idx = next3(k);
        e.b_idx = next3(next3(k));
      end else begin
        e.a_idx = next3(next3(k));
        e.b_idx = next3(k);
        e.mode  = ACC_SUB;
        case (grp)
          2'd0:    e.wb = WB_T;
          2'd1:    e.wb = WB_C;
          default: e.wb = WB_E;
        endcase
      end
    end else if (idx < SIDX_W'(27)) begin
      k = 2'(idx - SIDX_W'(24));
      e.a_idx = k;
      e.b_idx = k;
      e.mode  = (k == 2'd0) ? ACC_LOAD : ACC_ADD;
      e.wb    = (k == 2'd2) ? WB_NORM : WB_NONE;
    end else begin
      e.a_src = SRC_THR;
      e.b_src = SRC_THR;
      e.wb    = WB_APPLY;
    end
    return e;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi_lim;
    logic signed [ACC_W-1:0] lo_lim;
    hi_lim = $signed({{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}});
    lo_lim = $signed({{(ACC_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}});
    if (v > hi_lim) return hi_lim[OUT_W-1:0];
    if (v < lo_lim) return lo_lim[OUT_W-1:0];
    return v[OUT_W-1:0];
  endfunction

endpackage

[rtl/core/lac_mul.sv]
// ----------------------------------------------------------------------------
// lac_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module lac_mul import lac_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [MAG_W-1:0] a,
  input  logic [MAG_W-1:0] b,
  output logic             done,
  output logic [PROD_W-1:0] prod
);

  localparam int CNT_W = $clog2(MAG_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [MAG_W-1:0] mcand;
  logic [MAG_W-1:0] mplier;
  logic [MAG_W-1:0] hi;
  logic [MAG_W:0]   sum;

  assign sum  = {1'b0, hi} + (mplier[0] ? {1'b0, mcand} : '0);
  assign prod = {hi, mplier};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand  <= b;
      mplier <= a;
      hi     <= '0;
    end else if (busy) begin
      hi     <= sum[MAG_W:1];
      mplier <= {sum[0], mplier[MAG_W-1:1]};
    end
  end

endmodule

[rtl/core/lac_div.sv]
// ----------------------------------------------------------------------------
// lac_div
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lac_div import lac_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] dreg;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] qsh;
  logic [DEN_W+1:0] trial;

  // shifted remainder minus divisor; sign bit says restore
  assign trial = {1'b0, rem, qsh[NUM_W-1]} - {2'b00, dreg};
  assign quo   = qsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dreg <= den;
      rem  <= '0;
      qsh  <= num;
    end else if (busy) begin
      if (!trial[DEN_W+1]) begin
        rem <= trial[DEN_W-1:0];
        qsh <= {qsh[NUM_W-2:0], 1'b1};
      end else begin
        rem <= {rem[DEN_W-2:0], qsh[NUM_W-1]};
        qsh <= {qsh[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

[rtl/core/lever_arm_accel_compensation.sv]
// ----------------------------------------------------------------------------
// lever_arm_accel_compensation
// Lever-arm centripetal and euler acceleration compensation for an IMU.
// ----------------------------------------------------------------------------
// One word in gives one word out. For each item a sequencer runs 28 products
// through a shared bit-serial multiplier and three quotients through a
// bit-serial divider. A new word is taken once the sequencer is back at rest,
// even while the previous result still waits on the output register.
module lever_arm_accel_compensation import lac_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [RATE_W-1:0]    rate_x,
  input  logic signed [RATE_W-1:0]    rate_y,
  input  logic signed [RATE_W-1:0]    rate_z,
  input  logic signed [ACCEL_W-1:0]   accel_x,
  input  logic signed [ACCEL_W-1:0]   accel_y,
  input  logic signed [ACCEL_W-1:0]   accel_z,
  input  logic [STEP_W-1:0]           step_us,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [OUT_W-1:0]     comp_x,
  output logic signed [OUT_W-1:0]     comp_y,
  output logic signed [OUT_W-1:0]     comp_z,
  output logic                        applied,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_LAUNCH, S_MUL, S_DIV, S_FIN} state_t;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

  state_t state;
  logic [SIDX_W-1:0] step;
  step_t cur;

  logic signed [LEVER_W-1:0] lever [3];
  logic [THR_W-1:0] thr;
  logic [TAU_W-1:0] tau;

  logic signed [RATE_W-1:0]  w    [3];
  logic signed [ACCEL_W-1:0] ain  [3];
  logic [STEP_W-1:0]         dt;
  logic signed [RATE_W-1:0]  prev [3];
  logic signed [OUT_W-1:0]   sm   [3];
  logic signed [T_W-1:0]     tv   [3];
  logic signed [CE_W-1:0]    cent [3];
  logic signed [CE_W-1:0]    eul  [3];
  logic signed [RATE_W:0]    dw   [3];
  logic [NORM_W-1:0]         norm;
  logic                      apply_flag;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_new;
  logic signed [ACC_W-1:0] pval;
  logic signed [ACC_W-1:0] fx_val;
  logic signed [ACC_W-1:0] nabs;
  logic signed [ACC_W-1:0] s_sum;
  logic signed [ACC_W-1:0] diff [3];
  logic signed [NUM_W:0]   q_s;
  logic psign, dsign, dzero;

  logic signed [OPD_W-1:0] opa, opb, abs_a, abs_b;
  logic mul_start, mul_done, div_start, div_done;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  quo;
  logic [DEN_W-1:0]  den;

  assign cur      = step_entry(step);
  assign in_stall = (state != S_IDLE);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dw[i]   = (RATE_W+1)'(w[i]) - (RATE_W+1)'(prev[i]);
      diff[i] = ACC_W'(ain[i]) - (ACC_W'(cent[i]) + ACC_W'(eul[i]));
    end
  end

  always_comb begin
    case (cur.a_src)
      SRC_DW:  opa = OPD_W'(dw[cur.a_idx]);
      SRC_DT:  opa = $signed(OPD_W'(dt));
      SRC_W:   opa = OPD_W'(w[cur.a_idx]);
      SRC_S:   opa = OPD_W'(sm[cur.a_idx]);
      SRC_THR: opa = $signed(OPD_W'(thr));
      default: opa = '0;
    endcase
    case (cur.b_src)
      SRC_MEGA: opb = OPD_W'(US_PER_S);
      SRC_S:    opb = OPD_W'(sm[cur.b_idx]);
      SRC_R:    opb = OPD_W'(lever[cur.b_idx]);
      SRC_T:    opb = OPD_W'(tv[cur.b_idx]);
      SRC_W:    opb = OPD_W'(w[cur.b_idx]);
      SRC_THR:  opb = $signed(OPD_W'(thr));
      default:  opb = '0;
    endcase
  end

  assign abs_a = opa[OPD_W-1] ? -opa : opa;
  assign abs_b = opb[OPD_W-1] ? -opb : opb;
  assign mul_start = (state == S_LAUNCH);

  lac_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (abs_a[MAG_W-1:0]),
    .b     (abs_b[MAG_W-1:0]),
    .done  (mul_done),
    .prod  (prod)
  );

  // signed product into the accumulator
  always_comb begin
    pval = $signed({1'b0, prod[ACC_W-2:0]});
    if (psign) pval = -pval;
    case (cur.mode)
      ACC_LOAD: acc_new = pval;
      ACC_ADD:  acc_new = acc + pval;
      ACC_SUB:  acc_new = acc - pval;
      default:  acc_new = pval;
    endcase
    fx_val = (acc_new + HALF) >>> FRAC_BITS;
    nabs   = acc_new[ACC_W-1] ? -acc_new : acc_new;
  end

  assign den       = DEN_W'(tau) + DEN_W'(dt);
  assign div_start = (state == S_MUL) && mul_done && (cur.wb == WB_DIV);

  lac_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (nabs[NUM_W-1:0]),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  // quotient truncates toward zero; zero divisor holds the filter
  always_comb begin
    q_s = $signed({1'b0, quo});
    if (dsign) q_s = -q_s;
    if (dzero) q_s = '0;
    s_sum = ACC_W'(sm[cur.ix]) + ACC_W'(q_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lever[0] <= '0;
      lever[1] <= '0;
      lever[2] <= '0;
      thr      <= THR_RESET;
      tau      <= TAU_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEVER_X: lever[0] <= cfg_data[LEVER_W-1:0];
        REG_LEVER_Y: lever[1] <= cfg_data[LEVER_W-1:0];
        REG_LEVER_Z: lever[2] <= cfg_data[LEVER_W-1:0];
        REG_THR:     thr      <= cfg_data[THR_W-1:0];
        REG_TAU:     tau      <= cfg_data[TAU_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        prev[i] <= '0;
        sm[i]   <= '0;
      end
    end else begin
      // a finishing item reloads the output register itself
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            w[0]   <= rate_x;
            w[1]   <= rate_y;
            w[2]   <= rate_z;
            ain[0] <= accel_x;
            ain[1] <= accel_y;
            ain[2] <= accel_z;
            dt     <= step_us;
            step   <= '0;
            state  <= S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          psign <= opa[OPD_W-1] ^ opb[OPD_W-1];
          state <= S_MUL;
        end
        S_MUL: begin
          if (mul_done) begin
            acc <= acc_new;
            case (cur.wb)
              WB_T:     tv[cur.ix]   <= fx_val[T_W-1:0];
              WB_C:     cent[cur.ix] <= fx_val[CE_W-1:0];
              WB_E:     eul[cur.ix]  <= fx_val[CE_W-1:0];
              WB_NORM:  norm         <= acc_new[NORM_W-1:0];
              WB_APPLY: apply_flag   <= (ACC_W'(norm) > acc_new);
              default: ;
            endcase
            if (cur.wb == WB_DIV) begin
              dsign <= acc_new[ACC_W-1];
              dzero <= (den == '0);
              state <= S_DIV;
            end else if (step == LAST_STEP) begin
              state <= S_FIN;
            end else begin
              step  <= step + 1'b1;
              state <= S_LAUNCH;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            sm[cur.ix]   <= sat32(s_sum);
            prev[cur.ix] <= w[cur.ix];
            step         <= step + 1'b1;
            state        <= S_LAUNCH;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            comp_x    <= apply_flag ? sat32(diff[0]) : OUT_W'(ain[0]);
            comp_y    <= apply_flag ? sat32(diff[1]) : OUT_W'(ain[1]);
            comp_z    <= apply_flag ? sat32(diff[2]) : OUT_W'(ain[2]);
            applied   <= apply_flag;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == S_MUL) else $error("multiplier finished outside its wait");
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV) else $error("divider finished outside its wait");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= LAST_STEP) else $error("sequencer step out of range");
  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && out_stall) |=> state == S_FIN)
    else $error("result overwritten while output stalled");
`endif

endmodule

[dv/lever_arm_accel_compensation_test.sv]
// ----------------------------------------------------------------------------
// lever_arm_accel_compensation_test
// Drives gyro and accel words into the block with random idle and stall gaps,
// predicts every compensated result with its own fixed-point model of the
// filter and lever-arm terms, and checks each output word field by field.
// ----------------------------------------------------------------------------
module lever_arm_accel_compensation_test import lac_pkg::*;;

  typedef struct {
    logic signed [RATE_W-1:0]  rx, ry, rz;
    logic signed [ACCEL_W-1:0] ax, ay, az;
    logic [STEP_W-1:0]         dt;
  } sample_t;

  typedef struct {
    logic signed [OUT_W-1:0] cx, cy, cz;
    logic                    app;
  } comp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [RATE_W-1:0]  rate_x = '0, rate_y = '0, rate_z = '0;
  logic signed [ACCEL_W-1:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic [STEP_W-1:0] step_us = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] comp_x, comp_y, comp_z;
  logic applied;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lever_arm_accel_compensation dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state and configuration
  longint lev [3];
  longint thr, tau;
  longint last_rate [3];
  longint ang_acc [3];

  sample_t pending_words[$];
  comp_t   expected_comp[$];
  int  mismatches = 0;
  int  accepted = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  longint cycles = 0;
  bit  driver_hold = 1'b0;
  bit  accept_seen = 1'b0;
  bit  accept_out = 1'b0;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // round to nearest, ties toward plus infinity
  function automatic longint fx_round(longint v);
    return (v + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  task automatic cross3(input longint a [3], input longint b [3], output longint o [3]);
    o[0] = fx_round(a[1] * b[2] - a[2] * b[1]);
    o[1] = fx_round(a[2] * b[0] - a[0] * b[2]);
    o[2] = fx_round(a[0] * b[1] - a[1] * b[0]);
  endtask

  task automatic predict_comp(input sample_t s);
    longint w [3];
    longint acc [3];
    longint t [3];
    longint cent [3];
    longint eul [3];
    longint den, num, q, norm2;
    comp_t c;
    w[0] = s.rx; w[1] = s.ry; w[2] = s.rz;
    acc[0] = s.ax; acc[1] = s.ay; acc[2] = s.az;
    den = tau + longint'(s.dt);
    for (int i = 0; i < 3; i++) begin
      num = (w[i] - last_rate[i]) * 1000000 - longint'(s.dt) * ang_acc[i];
      q = (den != 0) ? num / den : 0;
      ang_acc[i] = clip32(ang_acc[i] + q);
      last_rate[i] = w[i];
    end
    cross3(w, lev, t);
    cross3(w, t, cent);
    cross3(ang_acc, lev, eul);
    norm2 = w[0] * w[0] + w[1] * w[1] + w[2] * w[2];
    c.app = norm2 > thr * thr;
    c.cx = OUT_W'(c.app ? clip32(acc[0] - (cent[0] + eul[0])) : acc[0]);
    c.cy = OUT_W'(c.app ? clip32(acc[1] - (cent[1] + eul[1])) : acc[1]);
    c.cz = OUT_W'(c.app ? clip32(acc[2] - (cent[2] + eul[2])) : acc[2]);
    expected_comp.push_back(c);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LEVER_X: lev[0] = longint'($signed(LEVER_W'(val)));
      REG_LEVER_Y: lev[1] = longint'($signed(LEVER_W'(val)));
      REG_LEVER_Z: lev[2] = longint'($signed(LEVER_W'(val)));
      REG_THR:     thr = val & 64'h3FFFFF;
      REG_TAU:     tau = val & 64'hFFFFF;
      default: ;
    endcase
  endtask

  // waits until every queued word has been sent and its result has come back
  task automatic drain_block();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_comp.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  function automatic longint rand_signed(int w);
    longint v;
    case ($urandom_range(0, 5))
      0: v = -(64'sd1 <<< (w - 1));
      1: v = (64'sd1 <<< (w - 1)) - 1;
      2: v = longint'($urandom_range(0, 2000)) - 1000;
      default: v = longint'($urandom) & ((64'sd1 <<< w) - 1);
    endcase
    v = v & ((64'sd1 <<< w) - 1);
    if (v >= (64'sd1 <<< (w - 1))) v = v - (64'sd1 <<< w);
    return v;
  endfunction

  function automatic sample_t rand_word(int rmax);
    sample_t s;
    if ($urandom_range(0, 9) == 0) begin
      s.rx = RATE_W'(rand_signed(RATE_W));
      s.ry = RATE_W'(rand_signed(RATE_W));
      s.rz = RATE_W'(rand_signed(RATE_W));
      s.ax = ACCEL_W'(rand_signed(ACCEL_W));
      s.ay = ACCEL_W'(rand_signed(ACCEL_W));
      s.az = ACCEL_W'(rand_signed(ACCEL_W));
      s.dt = STEP_W'($urandom);
    end else begin
      s.rx = RATE_W'($signed($urandom_range(0, 2 * rmax)) - rmax);
      s.ry = RATE_W'($signed($urandom_range(0, 2 * rmax)) - rmax);
      s.rz = RATE_W'($signed($urandom_range(0, 2 * rmax)) - rmax);
      s.ax = ACCEL_W'($signed($urandom_range(0, 31457280)) - 15728640);
      s.ay = ACCEL_W'($signed($urandom_range(0, 31457280)) - 15728640);
      s.az = ACCEL_W'($signed($urandom_range(0, 31457280)) - 15728640);
      s.dt = STEP_W'($urandom_range(0, 10000));
    end
    return s;
  endfunction

  function automatic sample_t make_word(longint r0, longint r1, longint r2,
                                        longint a0, longint a1, longint a2, longint d);
    sample_t s;
    s.rx = RATE_W'(r0); s.ry = RATE_W'(r1); s.rz = RATE_W'(r2);
    s.ax = ACCEL_W'(a0); s.ay = ACCEL_W'(a1); s.az = ACCEL_W'(a2);
    s.dt = STEP_W'(d);
    return s;
  endfunction

  task automatic run_phase(int n, int rmax);
    for (int i = 0; i < n; i++) pending_words.push_back(rand_word(rmax));
    drain_block();
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        // offered with no stall; the block takes it at the coming rising edge
      end
      if (!in_valid || accept_seen) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0 && !driver_hold) begin
          sample_t s;
          s = pending_words.pop_front();
          rate_x <= s.rx; rate_y <= s.ry; rate_z <= s.rz;
          accel_x <= s.ax; accel_y <= s.ay; accel_z <= s.az;
          step_us <= s.dt;
          in_valid <= 1'b1;
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (out_stall || !out_valid || accept_out) begin
        out_stall <= 1'b0;
        if (accept_out && $urandom_range(0, 3) != 0) begin
          stall_left <= $urandom_range(0, 16);
          out_stall <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    accept_seen <= 1'b0;
    accept_out <= 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        sample_t s;
        s = make_word(rate_x, rate_y, rate_z, accel_x, accel_y, accel_z, step_us);
        predict_comp(s);
        accepted <= accepted + 1;
        accept_seen <= 1'b1;
      end
      if (out_valid && !out_stall) begin
        comp_t e;
        accept_out <= 1'b1;
        if (expected_comp.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result word %0d %0d %0d %0b",
                                        comp_x, comp_y, comp_z, applied);
        end else begin
          e = expected_comp.pop_front();
          if (comp_x !== e.cx || comp_y !== e.cy || comp_z !== e.cz ||
              applied !== e.app) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp %0d %0d %0d %0b got %0d %0d %0d %0b",
                       e.cx, e.cy, e.cz, e.app, comp_x, comp_y, comp_z, applied);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 64'd4000000) begin
      $display("FAIL lever_arm_accel_compensation");
      $finish;
    end
  end

  initial begin
    lev[0] = 0; lev[1] = 0; lev[2] = 0;
    thr = longint'(THR_RESET);
    tau = longint'(TAU_RESET);
    for (int i = 0; i < 3; i++) begin
      last_rate[i] = 0;
      ang_acc[i] = 0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset configuration first: first sample steps from zero
    pending_words.push_back(make_word(100000, -50000, 30000, 65536, -65536, 0, 1000));
    pending_words.push_back(make_word(0, 0, 0, 0, 0, 0, 0));
    drain_block();

    write_reg(REG_LEVER_X, 262144);
    write_reg(REG_LEVER_Y, -262144);
    write_reg(REG_LEVER_Z, 13107);
    write_reg(REG_THR, 0);
    write_reg(REG_TAU, 1);
    write_reg(3'd7, 12345);   // unknown index, ignored
    pending_words.push_back(make_word(2293760, 2293760, 2293760,
                                      15728640, 15728640, 15728640, 10000));
    pending_words.push_back(make_word(-2293760, -2293760, -2293760,
                                      -15728640, -15728640, -15728640, 1));
    pending_words.push_back(make_word(-4194304, 4194303, -4194304,
                                      -16777216, 16777215, -16777216, 16383));
    pending_words.push_back(make_word(4194303, -4194304, 4194303,
                                      16777215, -16777216, 16777215, 0));
    pending_words.push_back(make_word(0, 0, 0, 1000, -1000, 7, 500));
    pending_words.push_back(make_word(1, 0, 0, 0, 0, 0, 0));
    drain_block();

    // zero step with zero tau holds the filter
    write_reg(REG_TAU, 0);
    write_reg(REG_THR, 2293760);
    pending_words.push_back(make_word(500000, -300000, 100000, 65536, 0, -65536, 0));
    pending_words.push_back(make_word(2293760, 0, 0, 65536, 0, 0, 0));
    pending_words.push_back(make_word(2293760, 2293760, 0, 65536, 0, 0, 20));
    pending_words.push_back(make_word(-2293760, 2293760, 2293760, 0, 5, 0, 0));
    drain_block();

    write_reg(REG_TAU, 1000000);
    write_reg(REG_THR, 4194303);
    write_reg(REG_LEVER_X, -524288);
    write_reg(REG_LEVER_Y, 524287);
    write_reg(REG_LEVER_Z, -1);
    pending_words.push_back(make_word(2293760, -2293760, 2293760, 0, 0, 0, 3));
    pending_words.push_back(make_word(-2293760, 2293760, -2293760, 0, 0, 0, 9999));
    drain_block();

    // random phases over several settings
    write_reg(REG_THR, 32768);
    write_reg(REG_TAU, 20000);
    write_reg(REG_LEVER_X, 6554);
    write_reg(REG_LEVER_Y, -3277);
    write_reg(REG_LEVER_Z, 9830);
    run_phase(100, 2293760);

    write_reg(REG_TAU, $urandom_range(1, 1000));
    write_reg(REG_THR, $urandom_range(0, 2293760));
    write_reg(REG_LEVER_X, $urandom_range(0, 524287) - 262144);
    write_reg(REG_LEVER_Y, $urandom_range(0, 524287) - 262144);
    write_reg(REG_LEVER_Z, $urandom_range(0, 524287) - 262144);
    run_phase(100, 2293760);

    // sender holds off midway until everything has come back
    for (int i = 0; i < 20; i++) pending_words.push_back(rand_word(300000));
    while (pending_words.size() > 10) @(posedge clk);
    driver_hold = 1'b1;
    do @(posedge clk);
    while (in_valid || expected_comp.size() != 0);
    driver_hold = 1'b0;
    drain_block();

    write_reg(REG_TAU, 0);
    write_reg(REG_THR, 65536);
    write_reg(REG_LEVER_X, 262144);
    write_reg(REG_LEVER_Y, 262144);
    write_reg(REG_LEVER_Z, -262144);
    run_phase(80, 400000);

    write_reg(REG_TAU, 1000000);
    write_reg(REG_THR, 0);
    write_reg(REG_LEVER_X, $urandom);
    write_reg(REG_LEVER_Y, $urandom);
    write_reg(REG_LEVER_Z, $urandom);
    run_phase(100, 2293760);

    if (mismatches == 0 && expected_comp.size() == 0) begin
      $display("PASS lever_arm_accel_compensation");
    end else begin
      $display("FAIL lever_arm_accel_compensation");
    end
    $finish;
  end

endmodule
